// ----- design/rab_pkg.sv -----
package rab_pkg;

    localparam int OperandWidth = 32;
    localparam int ProdWidth    = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] a_num;
        logic [30:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
    } t_req;

    typedef struct packed {
        logic [63:0] res_num;
        logic [62:0] res_den;
        logic        div_by_zero;
    } t_res;

    // Control from the sequencer to the shared datapath.
    typedef struct packed {
        logic start;
        logic sel_a;
    } t_div_ctl;

endpackage

// ----- design/rab_div.sv -----
// Restoring divider, one quotient bit a cycle; quotient of 64/64 bits.
module rab_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [63:0]           i_dividend,
    input  logic [63:0]           i_divisor,
    output logic                  o_done,
    output logic [63:0]           o_quot
);
    import rab_pkg::*;

    logic [63:0] r_quot, n_quot;
    logic [63:0] r_rem,  n_rem;
    logic [63:0] r_dsr;
    logic [6:0]  r_cnt,  n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_trial;
    logic [64:0] w_diff;

    always_comb begin
        w_trial = {r_rem, r_quot[63]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                n_rem  = w_diff[63:0];
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_trial[63:0];
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(ProdWidth - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) r_dsr <= i_divisor;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- design/rational_arith_binary_gcd_core.sv -----
// Products are formed in S_MUL1 and S_MUL2 (S_MUL2 runs twice for add and subtract),
// then numerator and denominator in S_FORM and magnitudes and sign in S_GINIT; then
// binary GCD steps (one shift or one subtract a cycle on 64-bit words) and two passes
// through the shared divider. Zero numerator or zero denominator: result set in S_GINIT.
// One request at a time; ready only in idle with no result pending, result held in an
// output register until taken. Reset (synchronous, active low) returns to idle.
module rational_arith_binary_gcd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rab_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output rab_pkg::t_res   o_res
);
    import rab_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_FORM  = 9'b000001000,
        S_GINIT = 9'b000010000,
        S_GCD   = 9'b000100000,
        S_DIVN  = 9'b001000000,
        S_DIVD  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [1:0]  r_op;
    logic signed [63:0] r_an, r_ad, r_bn, r_bd;
    logic signed [63:0] r_p0, r_p1;   // shared multiplier results
    logic signed [63:0] r_n, r_d;
    logic [63:0] r_u, r_v, r_nm, r_dm;
    logic [6:0]  r_sh;
    logic        r_neg;
    logic [63:0] r_qn;
    t_res        r_res;
    logic        r_ovalid;

    // shared multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mp;
    assign w_mp = w_ma * w_mb;

    always_comb begin
        w_ma = r_an[31:0];
        w_mb = r_bd[31:0];
        if (r_state == S_MUL1) begin
            w_ma = (r_op == OP_MUL) ? r_an[31:0] : r_an[31:0];
            w_mb = (r_op == OP_MUL) ? r_bn[31:0] : r_bd[31:0];
        end else begin
            w_ma = (r_op == OP_MUL || r_op == OP_DIV) ? r_ad[31:0] : r_bn[31:0];
            w_mb = (r_op == OP_DIV) ? r_bn[31:0] : (r_op == OP_MUL) ? r_bd[31:0]
                                                                     : r_ad[31:0];
        end
    end

    // second product pass for add and subtract: denominator ad*bd
    logic signed [63:0] r_p2;

    t_div_ctl w_dctl;
    logic        w_ddone;
    logic [63:0] w_dq;
    logic [63:0] w_g;
    assign w_g = r_u << r_sh;

    rab_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dctl.start),
        .i_dividend(w_dctl.sel_a ? r_nm : r_dm),
        .i_divisor (w_g),
        .o_done    (w_ddone),
        .o_quot    (w_dq)
    );

    logic r_started;

    always_comb begin
        w_dctl.start = 1'b0;
        w_dctl.sel_a = (r_state == S_DIVN);
        if ((r_state == S_DIVN || r_state == S_DIVD) && !r_started)
            w_dctl.start = 1'b1;
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    logic [1:0] r_mph;   // sub-phase within product stages

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
            r_mph     <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op    <= i_req.req_type;
                        r_an    <= 64'(signed'(i_req.a_num));
                        r_bn    <= 64'(signed'(i_req.b_num));
                        r_ad    <= {33'd0, i_req.a_den};
                        r_bd    <= {33'd0, i_req.b_den};
                        r_mph   <= '0;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p0    <= w_mp;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // MUL2 runs twice for add/sub: bn*ad then bd*ad
                    if ((r_op == OP_ADD || r_op == OP_SUB) && r_mph == 2'd0) begin
                        r_p1  <= w_mp;
                        r_mph <= 2'd1;
                        r_bn  <= r_bd;
                    end else begin
                        if (r_op == OP_ADD || r_op == OP_SUB) r_p2 <= w_mp;
                        else r_p1 <= w_mp;
                        r_state <= S_FORM;
                    end
                end
                S_FORM: begin
                    unique case (t_op'(r_op))
                        OP_ADD: begin r_n <= r_p0 + r_p1; r_d <= r_p2; end
                        OP_SUB: begin r_n <= r_p0 - r_p1; r_d <= r_p2; end
                        default: begin r_n <= r_p0; r_d <= r_p1; end
                    endcase
                    r_state <= S_GINIT;
                end
                S_GINIT: begin
                    r_neg <= r_n[63] ^ r_d[63];
                    r_nm  <= r_n[63] ? 64'(-r_n) : r_n;
                    r_dm  <= r_d[63] ? 64'(-r_d) : r_d;
                    r_u   <= r_n[63] ? 64'(-r_n) : r_n;
                    r_v   <= r_d[63] ? 64'(-r_d) : r_d;
                    r_sh  <= '0;
                    if (r_d == 0 || r_n == 0) begin
                        r_res.res_num     <= '0;
                        r_res.res_den     <= 63'd1;
                        r_res.div_by_zero <= (r_d == 0);
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // one step: strip common twos, strip twos, subtract, or go on to division when equal
                    if (!r_u[0] && !r_v[0]) begin
                        r_u  <= r_u >> 1;
                        r_v  <= r_v >> 1;
                        r_sh <= r_sh + 7'd1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u == r_v) begin
                        r_state   <= S_DIVN;
                        r_started <= 1'b0;
                    end else if (r_u > r_v) begin
                        r_u <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
                S_DIVN: begin
                    if (r_started && w_ddone) begin
                        r_qn      <= w_dq;
                        r_started <= 1'b0;
                        r_state   <= S_DIVD;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                S_DIVD: begin
                    if (r_started && w_ddone) begin
                        r_res.res_num     <= r_neg ? 64'(-r_qn) : r_qn;
                        r_res.res_den     <= w_dq[62:0];
                        r_res.div_by_zero <= 1'b0;
                        r_ovalid          <= 1'b1;
                        r_started         <= 1'b0;
                        r_state           <= S_IDLE;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

endmodule

// ----- design/rab_checker.sv -----
module rab_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input rab_pkg::t_res o_res
);
    import rab_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready again right after taking a request");

    a_dbz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.div_by_zero |-> o_res.res_num == 64'd0 && o_res.res_den == 63'd1)
        else $error("division by zero not 0/1");

    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.res_den != 63'd0)
        else $error("zero denominator");

endmodule

bind rational_arith_binary_gcd_core rab_checker u_rab_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_res  (o_res)
);

// ----- dv/tb_top.sv -----
module tb_top;
    import rab_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_res  o_res;

    rational_arith_binary_gcd_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    t_res   expected_fracs[$];
    int     mismatch_count;
    int     cycle_count;
    int     result_count;
    bit     sink_idle_en;
    bit     src_idle_en;
    int     hold_off_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] stein_gcd64(logic [63:0] u, logic [63:0] v);
        int sh;
        logic [63:0] t;
        if (u == 0) return v;
        if (v == 0) return u;
        sh = 0;
        while (sh < 63 && !(((u | v) >> sh) & 1)) sh++;
        while (!u[0]) u = u >> 1;
        do begin
            while (!v[0]) v = v >> 1;
            if (u > v) begin
                t = u;
                u = v;
                v = t;
            end
            v = v - u;
        end while (v != 0);
        return u << sh;
    endfunction

    function automatic t_res reduce_fraction(t_req r);
        longint an, bn, ad, bd, n, d;
        logic [63:0] nm, dm, g;
        bit neg;
        t_res res;
        an = longint'(signed'(r.a_num));
        bn = longint'(signed'(r.b_num));
        ad = longint'({33'd0, r.a_den});
        bd = longint'({33'd0, r.b_den});
        case (t_op'(r.req_type))
            OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            OP_MUL: begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        res.res_num     = 64'd0;
        res.res_den     = 63'd1;
        res.div_by_zero = 1'b0;
        if (d == 0) begin
            res.div_by_zero = 1'b1;
            return res;
        end
        if (n == 0) return res;
        neg = (n < 0) != (d < 0);
        nm  = n < 0 ? -n : n;
        dm  = d < 0 ? -d : d;
        g   = stein_gcd64(nm, dm);
        nm  = nm / g;
        dm  = dm / g;
        res.res_num = neg ? -nm : nm;
        res.res_den = dm[62:0];
        return res;
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count <= result_count + 1;
            if (expected_fracs.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result num=%0d den=%0d dbz=%0b",
                             $signed(o_res.res_num), o_res.res_den, o_res.div_by_zero);
            end else begin
                want = expected_fracs.pop_front();
                if (o_res.res_num !== want.res_num || o_res.res_den !== want.res_den ||
                    o_res.div_by_zero !== want.div_by_zero) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d/%0d dbz=%0b got %0d/%0d dbz=%0b",
                                 $signed(want.res_num), want.res_den, want.div_by_zero,
                                 $signed(o_res.res_num), o_res.res_den,
                                 o_res.div_by_zero);
                end
            end
        end
    end

    // Receiver: random stalls, with a counted hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (sink_idle_en) begin
            i_ready <= ($urandom_range(99) >= 33);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Valid stays high after acceptance until the next call or wait_drained drives it
    task automatic send_request(t_req r);
        while (src_idle_en && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req   <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_fracs.push_back(reduce_fraction(r));
        @(negedge i_clk);
    endtask

    function automatic t_req make_req(t_op op, logic [31:0] an, logic [30:0] ad,
                                      logic [31:0] bn, logic [30:0] bd);
        t_req r;
        r.req_type = op;
        r.a_num    = an;
        r.a_den    = ad;
        r.b_num    = bn;
        r.b_den    = bd;
        return r;
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(40)) - 20);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($urandom_range(1000)) << $urandom_range(20);
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(3))
            0: return 31'($urandom_range(31'h7fff_ffff, 1));
            1: return 31'($urandom_range(30, 1));
            2: return $urandom_range(1) ? 31'h7fff_ffff : 31'h4000_0000;
            default: return 31'($urandom_range(500, 1)) << $urandom_range(16);
        endcase
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_fracs.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_request(make_req(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
        send_request(make_req(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
        send_request(make_req(OP_MUL, 32'd0, 31'd5, 32'd7, 31'd3));
        send_request(make_req(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd9));
        send_request(make_req(OP_DIV, 32'd0, 31'd4, 32'd0, 31'd9));
        send_request(make_req(OP_DIV, -32'sd6, 31'd4, -32'sd9, 31'd2));
        send_request(make_req(OP_DIV, 32'd6, 31'd4, -32'sd9, 31'd2));
        send_request(make_req(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1));
        send_request(make_req(OP_ADD, 32'h8000_0000, 31'h7fff_ffff,
                              32'h8000_0000, 31'h7fff_ffff));
        send_request(make_req(OP_SUB, 32'h7fff_ffff, 31'h7fff_ffff,
                              32'h8000_0000, 31'h7fff_fffe));
        send_request(make_req(OP_MUL, 32'h7fff_ffff, 31'h7fff_ffff,
                              32'h7fff_ffff, 31'h7fff_ffff));
        send_request(make_req(OP_DIV, 32'h8000_0000, 31'h7fff_ffff,
                              32'h7fff_ffff, 31'h7fff_ffff));
        send_request(make_req(OP_ADD, 32'hffff_ffff, 31'd1, 32'd1, 31'd1));
        send_request(make_req(OP_MUL, 32'h5555_5555, 31'h2aaa_aaaa,
                              32'haaaa_aaaa, 31'h5555_5555));
        send_request(make_req(OP_DIV, 32'd1024, 31'h4000_0000, 32'd4096, 31'd1));
        send_request(make_req(OP_ADD, 32'd0, 31'd1, 32'd0, 31'd1));
        // zero denominators lie outside the range but must still flag
        send_request(make_req(OP_MUL, 32'd5, 31'd0, 32'd3, 31'd7));
        send_request(make_req(OP_ADD, 32'd5, 31'd3, 32'd3, 31'd0));
        wait_drained();
    endtask

    task automatic test_random(int n);
        t_req r;
        for (int k = 0; k < n; k++) begin
            r = make_req(t_op'($urandom_range(3)), rand_num(), rand_den(),
                         rand_num(), rand_den());
            send_request(r);
        end
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 3000;
        test_random(20);
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req           = '0;
        i_ready         = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        result_count    = 0;
        hold_off_cycles = 0;
        sink_idle_en    = 1'b1;
        src_idle_en     = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(300);
        // stretch with no idling on either side
        sink_idle_en = 1'b0;
        src_idle_en  = 1'b0;
        test_random(150);
        sink_idle_en = 1'b1;
        src_idle_en  = 1'b1;
        test_back_pressure();
        test_random(230);

        wait_drained();
        repeat (400) @(negedge i_clk);
        if (mismatch_count == 0 && expected_fracs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
